@@ src/feistel_block_cipher_128_assert.svh @@
// Assertion macros for the 128-bit Feistel block cipher.
// Included by the top level; no other dependencies.
`ifndef FEISTEL_BLOCK_CIPHER_128_ASSERT_SVH
`define FEISTEL_BLOCK_CIPHER_128_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication
`define FBC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fbc assertion failed");

// next-cycle implication
`define FBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fbc assertion failed");

`else

`define FBC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define FBC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ src/fbc_pkg.sv @@
// Shared types, constants and round/key-schedule functions for the Feistel cipher.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fbc_pkg;

	localparam int ROUND_COUNT = 32;
	localparam int HALF_W      = 64;

	localparam logic [HALF_W-1:0] ROUND_CONST_F = 64'h9e3779b97f4a7c15;
	localparam logic [HALF_W-1:0] ROUND_CONST_K = 64'hb5c0fbcfec4d3b2f;
	localparam logic [HALF_W-1:0] SEED_ZERO_KEY = 64'd1;

	// config register map
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_UPPER = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOWER = 1'b1;

	// key row settle time after reset or any key write
	localparam int SETTLE_CNT = ROUND_COUNT + 1;
	localparam int SETTLE_W   = $clog2(SETTLE_CNT + 1);

	typedef logic [HALF_W-1:0] half_t;

	// one block in flight between round cells
	typedef struct packed {
		logic  valid;
		logic  kind;   // 0 encrypt, 1 decrypt
		half_t left;
		half_t right;
	} fbc_beat_t;

	// F(x) = (rotl2 & rotl7) ^ rotl11 ^ CF
	function automatic half_t round_fn(input half_t x);
		half_t r2;
		half_t r7;
		half_t r11;
		r2  = {x[61:0], x[63:62]};
		r7  = {x[56:0], x[63:57]};
		r11 = {x[52:0], x[63:53]};
		return (r2 & r7) ^ r11 ^ ROUND_CONST_F;
	endfunction

	// one forward LFSR shift, taps 63,61,56,31,28,23,0
	function automatic half_t lfsr_step(input half_t s);
		return {s[62:0], s[63] ^ s[61] ^ s[56] ^ s[31] ^ s[28] ^ s[23] ^ s[0]};
	endfunction

endpackage

`default_nettype wire

@@ src/feistel_block_cipher_128.sv @@
// 128-bit Feistel block cipher, one cell per round, one block per clock
// while neither settling nor res_stall holds it. Takes one beat per cycle
// on the same terms: a beat is accepted on blk_valid with blk_stall low
// and its result passes each round cell's stage register in turn before
// it shows on res_valid. Every round cell has its own stage register and
// a ready chain, so gaps close up and a stalled result does not block
// blocks that can still move into empty cells. Encrypt and decrypt beats
// mix freely. The key row regenerates the LFSR states s_0..s_31 one cell
// per cycle from key_upper, so after reset and after any key write
// blk_stall stays high until the settle counter has run down to zero.
// Key writes are taken at any time (cfg_ready is tied high) but must
// only be issued while no block is in flight.
// Depends on fbc_pkg, fbc_key_cell, fbc_round_cell and the assert header.
`timescale 1ns / 1ps
`default_nettype none

`include "feistel_block_cipher_128_assert.svh"

module feistel_block_cipher_128 (
	input  wire logic                            clk,
	input  wire logic                            arst_n,

	// block input channel
	input  wire logic                            blk_valid,
	output logic                                 blk_stall,
	input  wire logic                            kind,
	input  wire fbc_pkg::half_t                   block_high,
	input  wire fbc_pkg::half_t                   block_low,

	// result channel
	output logic                                 res_valid,
	input  wire logic                            res_stall,
	output fbc_pkg::half_t                        result_high,
	output fbc_pkg::half_t                        result_low,

	// key write channel
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [fbc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire fbc_pkg::half_t                   cfg_data
);
	import fbc_pkg::*;

	// ---------------------------------------------------------------
	// Key registers and settle counter
	// ---------------------------------------------------------------
	half_t               key_upper_q;
	half_t               key_lower_q;
	logic [SETTLE_W-1:0] settle_q;
	logic                cfg_write;
	logic                settling;

	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;
	assign settling  = (settle_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_upper_q <= '0;
			key_lower_q <= '0;
			settle_q    <= SETTLE_W'(SETTLE_CNT);
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_KEY_UPPER: key_upper_q <= cfg_data;
					REG_KEY_LOWER: key_lower_q <= cfg_data;
					default: ;
				endcase
				settle_q <= SETTLE_W'(SETTLE_CNT);
			end else if (settling) begin
				settle_q <= settle_q - SETTLE_W'(1);
			end
		end
	end

	// ---------------------------------------------------------------
	// Key row: cell i holds s_i; a zero upper key seeds the LFSR with 1
	// ---------------------------------------------------------------
	half_t seed;
	half_t s_next [ROUND_COUNT];
	half_t rk     [ROUND_COUNT];

	assign seed = (key_upper_q != '0) ? key_upper_q : SEED_ZERO_KEY;

	for (genvar i = 0; i < ROUND_COUNT; i++) begin : g_key
		if (i == 0) begin : g_first
			fbc_key_cell u_key (
				.clk       (clk),
				.s_in      (seed),
				.key_lower (key_lower_q),
				.s_next    (s_next[i]),
				.round_key (rk[i])
			);
		end else begin : g_rest
			fbc_key_cell u_key (
				.clk       (clk),
				.s_in      (s_next[i-1]),
				.key_lower (key_lower_q),
				.s_next    (s_next[i]),
				.round_key (rk[i])
			);
		end
	end

	// ---------------------------------------------------------------
	// Round row: cell i applies round key i (encrypt) or
	// ROUND_COUNT-1-i (decrypt); beat[i] feeds cell i.
	// ---------------------------------------------------------------
	fbc_beat_t beat [ROUND_COUNT+1];
	logic      rdy  [ROUND_COUNT+1];

	assign beat[0] = '{valid: blk_valid && !settling, kind: kind,
		left: block_high, right: block_low};
	assign blk_stall = settling || !rdy[0];

	for (genvar i = 0; i < ROUND_COUNT; i++) begin : g_round
		fbc_round_cell u_round (
			.clk      (clk),
			.arst_n   (arst_n),
			.up       (beat[i]),
			.up_ready (rdy[i]),
			.dn       (beat[i+1]),
			.dn_ready (rdy[i+1]),
			.key_enc  (rk[i]),
			.key_dec  (rk[ROUND_COUNT-1-i])
		);
	end

	// last cell register doubles as the output register
	assign rdy[ROUND_COUNT] = !res_stall;
	assign res_valid        = beat[ROUND_COUNT].valid;
	assign result_high      = beat[ROUND_COUNT].left;
	assign result_low       = beat[ROUND_COUNT].right;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	// a key write must hold off blocks while the key row refills
	`FBC_ASSERT_NEXT(a_cfg_blocks_input, clk, arst_n, cfg_write, blk_stall)
	// an accepted beat lands in the first round cell
	`FBC_ASSERT_NEXT(a_accept_fills_cell0, clk, arst_n, blk_valid && !blk_stall, beat[1].valid)
	// nothing enters the row while the key row is still settling
	`FBC_ASSERT_SAME(a_no_entry_settling, clk, arst_n, settling, !beat[0].valid)

endmodule

`default_nettype wire

@@ src/fbc_key_cell.sv @@
// One key-schedule cell: holds LFSR state s_i and forms round key i.
// Depends on fbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fbc_key_cell (
	input  wire logic          clk,
	input  wire fbc_pkg::half_t s_in,
	input  wire fbc_pkg::half_t key_lower,
	output fbc_pkg::half_t      s_next,
	output fbc_pkg::half_t      round_key
);
	import fbc_pkg::*;

	half_t s_q;

	always_ff @(posedge clk) begin
		s_q <= s_in;
	end

	assign s_next    = lfsr_step(s_q);
	assign round_key = key_lower ^ s_q ^ ROUND_CONST_K;

endmodule

`default_nettype wire

@@ src/fbc_round_cell.sv @@
// One Feistel round cell with its own stage register and ready chain.
// Depends on fbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fbc_round_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire fbc_pkg::fbc_beat_t up,
	output logic                   up_ready,
	output fbc_pkg::fbc_beat_t      dn,
	input  wire logic              dn_ready,
	input  wire fbc_pkg::half_t     key_enc,
	input  wire fbc_pkg::half_t     key_dec
);
	import fbc_pkg::*;

	logic  valid_q;
	logic  kind_q;
	half_t left_q;
	half_t right_q;

	logic  take;
	half_t mix;
	half_t left_d;
	half_t right_d;

	assign up_ready = !valid_q || dn_ready;
	assign take     = up.valid && up_ready;

	// decrypt runs F on the right half and writes the result back to the right
	assign mix = round_fn(up.kind ? up.right : up.left) ^ (up.kind ? key_dec : key_enc);

	always_comb begin
		if (up.kind) begin
			left_d  = up.right;
			right_d = up.left ^ mix;
		end else begin
			left_d  = up.right ^ mix;
			right_d = up.left;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_q  <= up.kind;
			left_q  <= left_d;
			right_q <= right_d;
		end
	end

	assign dn = '{valid: valid_q, kind: kind_q, left: left_q, right: right_q};

endmodule

`default_nettype wire

@@ tb/feistel_block_cipher_128_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for feistel_block_cipher_128. It drives blocks under several
// keys and handshake pressures, predicts each result in line and checks results in order.
// Depends on fbc_pkg and the feistel_block_cipher_128 RTL.

module feistel_block_cipher_128_tb;
	import fbc_pkg::*;

	// direction selector on the kind input
	localparam logic KIND_ENCRYPT = 1'b0;
	localparam logic KIND_DECRYPT = 1'b1;

	// feedback taps of the round-key shift register: bits 63,61,56,31,28,23,0
	localparam half_t KEY_TAPS = 64'hA1000000_90800001;

	// Slowest honest run is roughly 1000 beats under heavy stalling, plus a
	// key-row settle and pipeline drain per key change and one long hold-off.
	// CYCLE_LIMIT is set well above what that run needs.
	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 400;
	localparam int MAX_REPORTED = 10;
	localparam int REKEY_EVERY  = 100;

	typedef struct packed {
		half_t high;
		half_t low;
	} block_t;

	// DUT ports, all inputs known from time zero
	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 blk_valid  = 1'b0;
	logic                 blk_stall;
	logic                 kind       = KIND_ENCRYPT;
	half_t                block_high = '0;
	half_t                block_low  = '0;
	logic                 res_valid;
	logic                 res_stall  = 1'b0;
	half_t                result_high;
	half_t                result_low;
	logic                 cfg_valid  = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index  = REG_KEY_UPPER;
	half_t                cfg_data   = '0;

	// mirror of the two key registers (reset value zero)
	half_t key_upper_m = '0;
	half_t key_lower_m = '0;

	// predicted output blocks, oldest first
	block_t expected_blocks_q[$];

	int mismatch_count = 0;
	int cycle_count    = 0;
	int send_idle_pct  = 0;
	int rcv_stall_pct  = 0;

	// hold-off request: the test flips hold_toggle, the receiver process counts
	logic hold_toggle = 1'b0;
	logic hold_seen   = 1'b0;
	int   hold_left   = 0;

	feistel_block_cipher_128 i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.blk_valid   (blk_valid),
		.blk_stall   (blk_stall),
		.kind        (kind),
		.block_high  (block_high),
		.block_low   (block_low),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.result_high (result_high),
		.result_low  (result_low),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Cipher prediction
	// ------------------------------------------------------------------

	function automatic half_t rotl(input half_t x, input int n);
		return (x << n) | (x >> (HALF_W - n));
	endfunction

	// round function: (x<<<2 & x<<<7) ^ x<<<11 ^ CF
	function automatic half_t feistel_mix(input half_t x);
		return (rotl(x, 2) & rotl(x, 7)) ^ rotl(x, 11) ^ ROUND_CONST_F;
	endfunction

	// one shift of the round-key register, parity of the taps into bit 0
	function automatic half_t key_reg_advance(input half_t s);
		return (s << 1) | half_t'(^(s & KEY_TAPS));
	endfunction

	// full block transform under the mirrored key; decrypt walks the keys backward
	function automatic block_t cipher_predict(input logic dir, input block_t din);
		half_t round_key [ROUND_COUNT];
		half_t seed;
		half_t l;
		half_t r;
		half_t t;
		// an all-zero upper key would lock the register, so it seeds with one
		seed = (key_upper_m != '0) ? key_upper_m : SEED_ZERO_KEY;
		for (int i = 0; i < ROUND_COUNT; i++) begin
			round_key[i] = key_lower_m ^ seed ^ ROUND_CONST_K;
			seed = key_reg_advance(seed);
		end
		l = din.high;
		r = din.low;
		if (dir == KIND_ENCRYPT) begin
			for (int i = 0; i < ROUND_COUNT; i++) begin
				t = r ^ feistel_mix(l) ^ round_key[i];
				r = l;
				l = t;
			end
		end else begin
			for (int i = ROUND_COUNT - 1; i >= 0; i--) begin
				t = r;
				r = l ^ feistel_mix(r) ^ round_key[i];
				l = t;
			end
		end
		return {l, r};
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic half_t rand_half();
		return {$urandom, $urandom};
	endfunction

	// edge-of-range data: zero, all ones, one-hot, one-cold, checkerboard
	function automatic half_t corner_half();
		case ($urandom_range(4))
			0: return '0;
			1: return '1;
			2: return half_t'(1) << $urandom_range(HALF_W - 1);
			3: return ~(half_t'(1) << $urandom_range(HALF_W - 1));
			default: return {32{2'b10}};
		endcase
	endfunction

	// keys lean toward the extremes so zero-seed and all-ones cases recur
	function automatic half_t pick_key();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			default: return rand_half();
		endcase
	endfunction

	// Offer one beat, with random idle cycles ahead of it, and hold it until
	// taken. The prediction is queued at the accepting edge.
	task automatic send_block(input logic dir, input block_t din, output block_t dout);
		while ($urandom_range(99) < send_idle_pct) begin
			blk_valid <= 1'b0;
			@(posedge clk);
		end
		blk_valid  <= 1'b1;
		kind       <= dir;
		block_high <= din.high;
		block_low  <= din.low;
		do @(posedge clk); while (blk_stall);
		dout = cipher_predict(dir, din);
		expected_blocks_q.push_back(dout);
	endtask

	// Drop valid and wait for every predicted block to come back. Always
	// waits on a clock edge first, so a following send never re-raises valid
	// in the same step.
	task automatic wait_drained();
		blk_valid <= 1'b0;
		do @(posedge clk); while (expected_blocks_q.size() != 0);
	endtask

	// Write both key halves back to back; only called with nothing in flight.
	task automatic set_keys(input half_t upper, input half_t lower);
		cfg_valid <= 1'b1;
		cfg_index <= REG_KEY_UPPER;
		cfg_data  <= upper;
		do @(posedge clk); while (!cfg_ready);
		key_upper_m = upper;
		cfg_index <= REG_KEY_LOWER;
		cfg_data  <= lower;
		do @(posedge clk); while (!cfg_ready);
		key_lower_m = lower;
		cfg_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Keys straight out of reset: upper half zero, so the seed is one.
	task automatic test_reset_key();
		block_t dout;
		send_block(KIND_ENCRYPT, '0, dout);
		send_block(KIND_ENCRYPT, '1, dout);
		send_block(KIND_DECRYPT, '0, dout);
		send_block(KIND_DECRYPT, '1, dout);
		wait_drained();
	endtask

	// Key extremes with edge data, plus an encrypt/decrypt round trip each.
	task automatic test_key_extremes();
		half_t  uppers [4];
		half_t  lowers [4];
		block_t dout;
		block_t ct;
		uppers = '{'1, '0, half_t'(1) << (HALF_W - 1), '0};
		lowers = '{'1, '1, '0, '0};
		for (int k = 0; k < 4; k++) begin
			set_keys(uppers[k], lowers[k]);
			send_block(KIND_ENCRYPT, {{32{2'b10}}, {32{2'b01}}}, dout);
			send_block(KIND_DECRYPT, {half_t'(1) << k, ~(half_t'(1) << (63 - k))}, dout);
			send_block(KIND_ENCRYPT, {rand_half(), rand_half()}, ct);
			send_block(KIND_DECRYPT, ct, dout);
			wait_drained();
		end
	endtask

	// Random traffic under the given idle rates, re-keyed every hundred beats.
	// About one pick in five is a round trip that feeds a predicted
	// ciphertext straight back for decryption.
	task automatic test_random_traffic(input int send_pct, input int rcv_pct,
			input int beats);
		block_t din;
		block_t dout;
		int     sent;
		int     pick;
		send_idle_pct = send_pct;
		rcv_stall_pct = rcv_pct;
		sent = 0;
		while (sent < beats) begin
			set_keys(pick_key(), pick_key());
			for (int n = 0; n < REKEY_EVERY; n++) begin
				pick = $urandom_range(99);
				if (pick < 20) begin
					send_block(KIND_ENCRYPT, {rand_half(), rand_half()}, dout);
					send_block(KIND_DECRYPT, dout, dout);
					n++;
				end else begin
					if (pick < 35)
						din = {corner_half(), corner_half()};
					else
						din = {rand_half(), rand_half()};
					send_block(logic'($urandom_range(1)), din, dout);
				end
			end
			sent += REKEY_EVERY;
			wait_drained();
		end
	endtask

	// Receiver holds off for a long stretch while the sender keeps offering,
	// so the round pipeline fills and pushes back on the input.
	task automatic test_input_backpressure();
		block_t dout;
		send_idle_pct = 0;
		rcv_stall_pct = 0;
		set_keys(rand_half(), rand_half());
		hold_toggle <= ~hold_toggle;
		for (int n = 0; n < 80; n++)
			send_block(logic'($urandom_range(1)), {rand_half(), rand_half()}, dout);
		wait_drained();
	endtask

	// ------------------------------------------------------------------
	// Receiver stall generation; a requested hold-off overrides it
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_toggle != hold_seen) begin
			hold_seen = hold_toggle;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(99) < rcv_stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Result checking: every accepted result beat against the oldest prediction
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		block_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_blocks_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTED)
					$display("unexpected result beat: high %h low %h",
						result_high, result_low);
			end else begin
				want = expected_blocks_q.pop_front();
				if (result_high !== want.high || result_low !== want.low) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTED)
						$display("result mismatch: high exp %h got %h, low exp %h got %h",
							want.high, result_high, want.low, result_low);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL feistel_block_cipher_128");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		// reset held low at start; the key row then settles behind blk_stall
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_key();
		test_key_extremes();
		test_random_traffic(29, 74, 280);
		test_random_traffic(74, 29, 280);
		test_random_traffic(0, 0, 280);
		test_input_backpressure();

		// catch any stray beats once the pipeline should be empty
		repeat (ROUND_COUNT + 8) @(posedge clk);
		if (expected_blocks_q.size() != 0) begin
			$display("%0d predicted blocks never arrived", expected_blocks_q.size());
			mismatch_count += expected_blocks_q.size();
		end
		if (mismatch_count == 0)
			$display("PASS feistel_block_cipher_128");
		else
			$display("FAIL feistel_block_cipher_128");
		$finish;
	end

endmodule
